[src/sensor_average_and_smoothing_core_defines.svh]
// Assertion macros used by sasc_checker.sv
`ifndef SENSOR_AVERAGE_AND_SMOOTHING_CORE_DEFINES_SVH
`define SENSOR_AVERAGE_AND_SMOOTHING_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SASC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SASC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sasc_pkg.sv]
package sasc_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int POS_OUT_W  = 4;
    localparam int TEMP_W     = 21;
    localparam int GAIN_W     = 8;
    localparam int OFFSET_W   = 16;
    localparam int ALPHA_W    = 9;

    // Stream widths (whole bytes)
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 80;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA  = 2'd2;

    localparam logic [GAIN_W-1:0]   GAIN_RST   = 8'd33;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 16'd17351;
    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 9'd205;

    // Smoothing weight of one, and the Q8 shift that goes with it
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
    localparam int                 ALPHA_SHIFT = 8;

    // gain * sample product, and the weighted smoothing terms
    localparam int PROD_W = GAIN_W + SAMPLE_W;
    localparam int WACC_W = TEMP_W + ALPHA_W + 1;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain;
        logic [OFFSET_W-1:0] offset;
        logic [ALPHA_W-1:0]  alpha;
    } cfg_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] smoothed;
        logic signed [TEMP_W-1:0] mtemp;
        logic signed [TEMP_W-1:0] inst;
        logic [POS_OUT_W-1:0]     pos;
        logic [SAMPLE_W-1:0]      mean;
    } res_t;

endpackage

[src/sensor_average_and_smoothing_core.sv]
// Channel   Direction  Beat fields
// s_*       in         tdata: sample[11:0], zero pad [15:12]
// m_*       out        tdata: mean_sample, next_position, instant_temp, mean_temp,
//                             smoothed_temp, zero pad [79]
// cfg_*     in         write: 0 temp_gain, 1 temp_offset, 2 smoothing_alpha
//
// Front takes a sample in F_IDLE, then does the ring update in F_UPD (registered
// ring read, then sum update) before it takes the next. Back steps each sample
// through B_MEAN, B_MUL and B_DONE (mean correction, then the two smoothing
// multiplies) and loads the next queue entry in B_IDLE or on leaving B_DONE.
// rst_n clears ring (valid bits), sum, position and smoothed value at once.
// The output register lets the back finish one more sample while m_tready is low.
module sensor_average_and_smoothing_core #(
    parameter int TAPS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // sample[11:0], zero pad above
    input  logic [sasc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mean_sample[11:0], next_position[15:12], instant_temp[36:16],
    // mean_temp[57:37], smoothed_temp[78:58], zero pad [79]
    output logic [sasc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_we,
    input  logic [sasc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [sasc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sasc_pkg::*;

    localparam int SUM_W   = SAMPLE_W + $clog2(TAPS);
    localparam int ENTRY_W = POS_OUT_W + SUM_W + SAMPLE_W;

    cfg_t               cfg_reg;
    res_t               res;
    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_in;
    logic [ENTRY_W-1:0] q_head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain   <= GAIN_RST;
            cfg_reg.offset <= OFFSET_RST;
            cfg_reg.alpha  <= ALPHA_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GAIN:   cfg_reg.gain   <= cfg_data[GAIN_W-1:0];
                REG_OFFSET: cfg_reg.offset <= cfg_data[OFFSET_W-1:0];
                REG_ALPHA:  cfg_reg.alpha  <= cfg_data[ALPHA_W-1:0];
                default:    ;
            endcase
        end
    end

    sasc_front #(
        .TAPS    (TAPS),
        .ENTRY_W (ENTRY_W)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sample  (s_tdata[SAMPLE_W-1:0]),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    sasc_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    sasc_back #(
        .TAPS    (TAPS),
        .ENTRY_W (ENTRY_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_head),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .res     (res)
    );

    // Output beat packing
    assign m_tdata = {1'b0, res.smoothed, res.mtemp, res.inst, res.pos, res.mean};

endmodule

[src/sasc_front.sv]
module sasc_front #(
    parameter int TAPS    = 16,
    parameter int ENTRY_W = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sasc_pkg::SAMPLE_W-1:0] sample,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [ENTRY_W-1:0]            q_data
);
    import sasc_pkg::*;

    localparam int PW    = $clog2(TAPS);
    localparam int SUM_W = SAMPLE_W + PW;

    localparam logic [PW-1:0] POS_LAST = PW'(TAPS - 1);

    localparam logic F_IDLE = 1'b0;
    localparam logic F_UPD  = 1'b1;

    logic                state_reg, state_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [TAPS-1:0]     valid_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] old_sample;
    logic                accept;

    logic [SAMPLE_W-1:0] ring_mem [TAPS];

    // Take a sample only when the queue has room for its entry next cycle
    assign s_ready = (state_reg == F_IDLE) && !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = (state_reg == F_UPD);

    // Ring slot being replaced; an unwritten slot counts as zero
    assign old_sample = valid_reg[pos_reg] ? rd_data_reg : '0;
    assign sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
    assign pos_next   = (pos_reg == POS_LAST) ? '0 : pos_reg + PW'(1);
    assign q_data     = {POS_OUT_W'(pos_next), sum_next, sample_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_UPD;
                end
            end
            F_UPD:
            begin
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            pos_reg   <= '0;
            sum_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_UPD)
            begin
                pos_reg            <= pos_next;
                sum_reg            <= sum_next;
                valid_reg[pos_reg] <= 1'b1;
            end
        end
    end

    // Held sample
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
        end
    end

    // Sample ring: one write, one registered read at the write position
    always_ff @(posedge clk)
    begin
        if (state_reg == F_UPD)
        begin
            ring_mem[pos_reg] <= sample_reg;
        end
        rd_data_reg <= ring_mem[pos_reg];
    end

endmodule

[src/sasc_queue.sv]
module sasc_queue #(
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              full,
    output logic              valid,
    output logic [DATA_W-1:0] head
);

    // Two-entry queue between front and back
    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/sasc_back.sv]
module sasc_back #(
    parameter int TAPS    = 16,
    parameter int ENTRY_W = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sasc_pkg::cfg_t     cfg,
    input  logic               q_valid,
    output logic               q_pop,
    input  logic [ENTRY_W-1:0] q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sasc_pkg::res_t     res
);
    import sasc_pkg::*;

    localparam int PW      = $clog2(TAPS);
    localparam int SUM_W   = SAMPLE_W + PW;
    localparam int RECIP_W = SUM_W - PW + 1;
    localparam int QP_W    = SUM_W + RECIP_W;

    // floor(2^SUM_W / TAPS): estimate is exact or one low
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((64'd1 << SUM_W) / TAPS);
    localparam logic [SUM_W-1:0]   TAPS_C = SUM_W'(TAPS);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MEAN = 2'd1;
    localparam logic [1:0] B_MUL  = 2'd2;
    localparam logic [1:0] B_DONE = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic                     out_free;
    logic                     load_head;

    logic [SAMPLE_W-1:0]      h_sample;
    logic [SUM_W-1:0]         h_sum;
    logic [POS_OUT_W-1:0]     h_pos;

    logic [SUM_W-1:0]         sum_reg;
    logic [POS_OUT_W-1:0]     pos_reg;
    logic [QP_W-1:0]          qprod_reg;
    logic [PROD_W-1:0]        iprod_reg;
    logic [SAMPLE_W-1:0]      mean_reg;
    logic signed [TEMP_W-1:0] inst_reg;
    logic signed [WACC_W-1:0] pa_reg;
    logic signed [WACC_W-1:0] pb_reg;
    logic [PROD_W-1:0]        mprod_reg;
    logic signed [TEMP_W-1:0] smoothed_reg;
    logic                     m_valid_reg;
    res_t                     res_reg;

    logic [SAMPLE_W-1:0]      q0;
    logic [SUM_W-1:0]         rem;
    logic [ALPHA_W-1:0]       a_eff;
    logic [ALPHA_W-1:0]       b_eff;
    logic signed [ALPHA_W:0]  a_s;
    logic signed [ALPHA_W:0]  b_s;
    logic signed [WACC_W-1:0] acc;
    logic signed [TEMP_W-1:0] sm_next;
    logic signed [TEMP_W-1:0] mtemp_next;

    // Queue entry fields
    assign h_sample = q_data[0 +: SAMPLE_W];
    assign h_sum    = q_data[SAMPLE_W +: SUM_W];
    assign h_pos    = q_data[SAMPLE_W + SUM_W +: POS_OUT_W];

    assign out_free  = !m_valid_reg || m_ready;
    assign load_head = q_valid &&
                       ((state_reg == B_IDLE) || ((state_reg == B_DONE) && out_free));
    assign q_pop     = load_head;

    // Mean: reciprocal estimate, then one correction step
    assign q0  = qprod_reg[SUM_W +: SAMPLE_W];
    assign rem = sum_reg - SUM_W'(q0) * TAPS_C;

    // Smoothing weights, alpha clamped to one
    assign a_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
    assign b_eff = ALPHA_ONE - a_eff;
    assign a_s   = signed'({1'b0, a_eff});
    assign b_s   = signed'({1'b0, b_eff});

    // Weighted sum, floor shift by taking the upper bits
    assign acc        = pa_reg + pb_reg;
    assign sm_next    = acc[ALPHA_SHIFT +: TEMP_W];
    assign mtemp_next = TEMP_W'(mprod_reg) - TEMP_W'(cfg.offset);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = B_MEAN;
                end
            end
            B_MEAN:
            begin
                state_next = B_MUL;
            end
            B_MUL:
            begin
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = q_valid ? B_MEAN : B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state, smoothed value and output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            smoothed_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == B_DONE) && out_free)
            begin
                smoothed_reg <= sm_next;
                m_valid_reg  <= 1'b1;
            end
            else if (m_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        if (load_head)
        begin
            sum_reg   <= h_sum;
            pos_reg   <= h_pos;
            qprod_reg <= QP_W'(h_sum) * QP_W'(RECIP);
            iprod_reg <= PROD_W'(cfg.gain) * PROD_W'(h_sample);
        end
        if (state_reg == B_MEAN)
        begin
            mean_reg <= q0 + SAMPLE_W'(rem >= TAPS_C);
            inst_reg <= TEMP_W'(iprod_reg) - TEMP_W'(cfg.offset);
            pa_reg   <= WACC_W'(a_s) * WACC_W'(smoothed_reg);
        end
        if (state_reg == B_MUL)
        begin
            pb_reg    <= WACC_W'(b_s) * WACC_W'(inst_reg);
            mprod_reg <= PROD_W'(cfg.gain) * PROD_W'(mean_reg);
        end
        if ((state_reg == B_DONE) && out_free)
        begin
            res_reg.mean     <= mean_reg;
            res_reg.pos      <= pos_reg;
            res_reg.inst     <= inst_reg;
            res_reg.mtemp    <= mtemp_next;
            res_reg.smoothed <= sm_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign res     = res_reg;

endmodule

[src/sasc_checker.sv]
`include "sensor_average_and_smoothing_core_defines.svh"

module sasc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [sasc_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready
);

    logic out_stall;

    assign out_stall = m_tvalid && !m_tready;

    // A stalled output beat stays put
    `SASC_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled beat changed")

    // Front takes no input beat during the ring update that follows each accepted beat
    `SASC_ASSERT_NEXT(a_in_gap, s_tvalid && s_tready, !s_tready, "input beat on ring update")

    // Nothing comes out in the first cycle after reset
    `SASC_ASSERT_NOW(a_rst_quiet, !$past(rst_n), !m_tvalid, "output beat straight after reset")

    // Pad bit of the output beat is always clear
    `SASC_ASSERT_NOW(a_out_pad, m_tvalid, !m_tdata[sasc_pkg::M_TDATA_W-1], "output pad bit set")

endmodule

bind sensor_average_and_smoothing_core sasc_checker u_sasc_checker (.*);

[verif/tb_sensor_average_and_smoothing_core.sv]
`timescale 1ns / 100ps

module tb_sensor_average_and_smoothing_core;
    import sasc_pkg::*;

    localparam int TAPS = 16;
    // index beyond the register file, writes to it must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_SAMPLES = 420;
    localparam longint signed TEMP_HI = 1048575;
    localparam longint signed TEMP_LO = -1048576;

    logic                  clk;
    logic                  rst_n;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Traffic shaping, set by the tests
    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;

    // Predictor state: register copy, sample ring, sum, position, smoothed value
    logic [GAIN_W-1:0]   gain_r;
    logic [OFFSET_W-1:0] offset_r;
    logic [ALPHA_W-1:0]  alpha_r;
    logic [SAMPLE_W-1:0] hist [TAPS];
    logic [15:0]         ring_sum;
    logic [3:0]          wr_pos;
    longint signed       smooth_q8;

    res_t expected_readings [$];
    int   samples_in;
    int   readings_checked;
    int   errors;

    sensor_average_and_smoothing_core #(
        .TAPS (TAPS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Overall time limit
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint signed clamp21(input longint signed v);
        if (v > TEMP_HI)
            return TEMP_HI;
        if (v < TEMP_LO)
            return TEMP_LO;
        return v;
    endfunction

    // Q8 degC map: gain * value - offset
    function automatic longint signed to_q8(input logic [SAMPLE_W-1:0] v);
        return clamp21(longint'(gain_r) * longint'(v) - longint'(offset_r));
    endfunction

    function automatic void apply_register(input logic [CFG_ADDR_W-1:0] addr,
                                           input logic [CFG_DATA_W-1:0] data);
        case (addr)
            REG_GAIN:   gain_r = data[GAIN_W-1:0];
            REG_OFFSET: offset_r = data[OFFSET_W-1:0];
            REG_ALPHA:  alpha_r = data[ALPHA_W-1:0];
            default:    ;
        endcase
    endfunction

    // Advance the ring and smoother by one sample, return the reading it gives
    function automatic res_t predict_reading(input logic [SAMPLE_W-1:0] s);
        res_t                r;
        logic [SAMPLE_W-1:0] mean;
        longint signed       w;
        longint signed       inst;
        longint signed       mtemp;
        longint signed       acc;
        w = (alpha_r > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_r);
        ring_sum = ring_sum - 16'(hist[wr_pos]) + 16'(s);
        hist[wr_pos] = s;
        wr_pos = wr_pos + 4'd1;
        mean = SAMPLE_W'(ring_sum / TAPS);
        inst = to_q8(s);
        mtemp = to_q8(mean);
        // arithmetic shift floors negative sums
        acc = w * smooth_q8 + (longint'(ALPHA_ONE) - w) * inst;
        smooth_q8 = clamp21(acc >>> ALPHA_SHIFT);
        r.mean = mean;
        r.pos = wr_pos;
        r.inst = inst[TEMP_W-1:0];
        r.mtemp = mtemp[TEMP_W-1:0];
        r.smoothed = smooth_q8[TEMP_W-1:0];
        return r;
    endfunction

    // Track register writes and accepted sample beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                apply_register(cfg_addr, cfg_data);
            if (s_tvalid && s_tready)
            begin
                expected_readings.push_back(predict_reading(s_tdata[SAMPLE_W-1:0]));
                samples_in++;
            end
        end
    end

    task automatic check_field(input string name, input longint signed want,
                               input longint signed got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = res_t'(m_tdata[$bits(res_t)-1:0]);
            if (expected_readings.size() == 0)
            begin
                $error("result beat with nothing expected: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_readings.pop_front();
                check_field("mean_sample", longint'(want.mean), longint'(got.mean));
                check_field("next_position", longint'(want.pos), longint'(got.pos));
                check_field("instant_temp", longint'(want.inst), longint'(got.inst));
                check_field("mean_temp", longint'(want.mtemp), longint'(got.mtemp));
                check_field("smoothed_temp", longint'(want.smoothed),
                            longint'(got.smoothed));
                readings_checked++;
            end
        end
    end

    // Receiver: long hold-off on request, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Called on a falling edge; returns on the falling edge after acceptance
    task automatic send_sample(input logic [S_TDATA_W-1:0] word);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Wait until every reading is back and the pipeline is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mix of full-range, rail and slowly drifting samples; pad bits now and then
    function automatic logic [S_TDATA_W-1:0] random_word(input logic [SAMPLE_W-1:0] prev);
        logic [SAMPLE_W-1:0] s;
        logic [3:0]          pad;
        case ($urandom_range(9))
            0:       s = '0;
            1:       s = '1;
            2, 3:    s = prev + SAMPLE_W'($urandom_range(15)) - SAMPLE_W'(8);
            default: s = SAMPLE_W'($urandom_range(4095));
        endcase
        pad = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'd0;
        return {pad, s};
    endfunction

    task automatic random_setup();
        logic [CFG_DATA_W-1:0] a;
        case ($urandom_range(7))
            0:       a = '0;
            1:       a = CFG_DATA_W'(ALPHA_ONE);
            2:       a = CFG_DATA_W'($urandom_range(511, 257));
            default: a = CFG_DATA_W'($urandom_range(255));
        endcase
        write_reg(REG_GAIN, CFG_DATA_W'($urandom));
        write_reg(REG_OFFSET, CFG_DATA_W'($urandom_range(65535)));
        write_reg(REG_ALPHA, a);
    endtask

    // Reset register values: rails, mid-scale, and set pad bits
    task automatic test_default_map();
        send_sample(16'h0000);
        send_sample(16'h0FFF);
        send_sample(16'hF000);
        send_sample(16'h5FFF);
        send_sample(16'h0800);
        send_sample(16'h0001);
        settle();
    endtask

    // Register extremes: zero alpha follows, full alpha holds, negative floor
    task automatic test_register_extremes();
        write_reg(REG_GAIN, 16'h00FF);
        write_reg(REG_OFFSET, 16'h0000);
        write_reg(REG_ALPHA, 16'h0000);
        send_sample(16'h0FFF);
        send_sample(16'h0FFF);
        send_sample(16'h0000);
        settle();
        write_reg(REG_GAIN, 16'h0000);
        write_reg(REG_OFFSET, 16'hFFFF);
        write_reg(REG_ALPHA, CFG_DATA_W'(ALPHA_ONE));
        send_sample(16'h04D2);
        send_sample(16'h0FFF);
        settle();
        write_reg(REG_ALPHA, 16'h0080);
        send_sample(16'h004D);
        send_sample(16'h0FA0);
        settle();
    endtask

    // Data bits above the gain and alpha widths, alpha beyond one, unused index
    task automatic test_register_masking();
        write_reg(REG_ALPHA, 16'hFFFF);
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_GAIN, 16'hAB55);
        write_reg(REG_OFFSET, 16'h1234);
        send_sample(16'h0ABC);
        send_sample(16'h0123);
        send_sample(16'h0FFF);
        settle();
    endtask

    // Random samples under four idling mixes, fresh registers for each
    task automatic test_random_traffic();
        logic [S_TDATA_W-1:0] word;
        int src_mix [4];
        int sink_mix [4];
        src_mix = '{0, 48, 0, 18};
        sink_mix = '{0, 0, 48, 18};
        word = '0;
        for (int ph = 0; ph < 4; ph++)
        begin
            random_setup();
            src_idle_pct = src_mix[ph];
            sink_stall_pct = sink_mix[ph];
            for (int i = 0; i < PHASE_SAMPLES; i++)
            begin
                word = random_word(word[SAMPLE_W-1:0]);
                send_sample(word);
            end
            settle();
        end
    endtask

    // Receiver holds off while samples keep coming, so the input backs up
    task automatic test_output_backpressure();
        logic [S_TDATA_W-1:0] word;
        word = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = HOLD_OFF_CYCLES;
        for (int i = 0; i < 48; i++)
        begin
            word = random_word(word[SAMPLE_W-1:0]);
            send_sample(word);
        end
        settle();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tdata = '0;
        s_tvalid = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_GAIN;
        cfg_data = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = 0;
        gain_r = GAIN_RST;
        offset_r = OFFSET_RST;
        alpha_r = ALPHA_RST;
        foreach (hist[i])
            hist[i] = '0;
        ring_sum = '0;
        wr_pos = '0;
        smooth_q8 = 0;
        samples_in = 0;
        readings_checked = 0;
        errors = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_map();
        test_register_extremes();
        test_register_masking();
        test_random_traffic();
        test_output_backpressure();

        if (expected_readings.size() != 0)
        begin
            $error("%0d readings never arrived", expected_readings.size());
            errors++;
        end
        $display("Run covered %0d samples and %0d checked readings: register rails,",
                 samples_in, readings_checked);
        $display("four idling mixes and a %0d-cycle receiver hold-off.", HOLD_OFF_CYCLES);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
